// ===== rtl/core/adaptive_velocity_to_duty_defines.svh =====
// ----------------------------------------------------------------------------
// adaptive velocity to duty assertion macros
// shared concurrent assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_VELOCITY_TO_DUTY_DEFINES_SVH
`define ADAPTIVE_VELOCITY_TO_DUTY_DEFINES_SVH

// condition holds at every edge out of reset
`define AVTD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define AVTD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AVTD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/avtd_pkg.sv =====
// ----------------------------------------------------------------------------
// avtd_pkg
// beat types, register indexes and reset values of the velocity to duty block
// ----------------------------------------------------------------------------
package avtd_pkg;

  // field widths
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned DUTY_W    = 10;
  localparam int unsigned CAPT_W    = 15;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // product widths: duty * magnitude and duty * duty
  localparam int unsigned PDS_W = DUTY_W + MAG_W;
  localparam int unsigned PDD_W = 2 * DUTY_W;

  // register reset values
  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST    = 10'd999;
  localparam logic [CAPT_W-1:0] CAPTURE_SPEED_RST = 15'd1536;
  localparam logic [GAIN_W-1:0] GAIN_FLOOR_RST    = 16'd1310;
  localparam logic [GAIN_W-1:0] GAIN_CEILING_RST  = 16'd3933;
  localparam logic [GAIN_W-1:0] GAIN_START_RST    = 16'd2621;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_LIMIT    = 3'd0,
    REG_CAPTURE_SPEED = 3'd1,
    REG_GAIN_FLOOR    = 3'd2,
    REG_GAIN_CEILING  = 3'd3,
    REG_GAIN_START    = 3'd4
  } cfg_reg_t;

  // item modes
  localparam logic MODE_COMMAND  = 1'b0;
  localparam logic MODE_ODOMETRY = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic signed [SPEED_W-1:0] speed_value;
  } in_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              direction;
    logic              direction_write;
    logic [GAIN_W-1:0] gain;
    logic              gain_updated;
  } out_beat_t;

endpackage

// ===== rtl/core/adaptive_velocity_to_duty.sv =====
// ----------------------------------------------------------------------------
// adaptive_velocity_to_duty
// velocity command to direction and pwm duty, with a gain fitted from odometry
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one item per beat: a
// velocity command (mode 0) or an odometry speed sample (mode 1). Every item
// gives exactly one result beat on out_valid/out_stall/out_data.
// One item is worked at a time. A command goes through a radix-2 serial
// divider of SDS_W+8 steps (42 at depth 200). A captured sample with a
// full window adds a read, two sum updates and the same divide. A sample
// that is not captured, or a command at zero gain, goes straight to the
// output stage; one that fills the window only adds to the sums; a
// full-window capture with an empty denominator skips the divide. The
// result sits in an output register, so the next item is taken while it
// waits; a stalled receiver holds the result and the block then stops at the
// end of the following item. Configuration writes (cfg_valid/cfg_ready,
// always ready) go to register cfg_index; the user must make them only while
// the block is idle, which the block does not enforce. Writing gain_start
// loads the current gain. Synchronous reset restores register defaults,
// empties the window (fill count zero, no clearing pass) and clears out_valid.
// ----------------------------------------------------------------------------
`include "adaptive_velocity_to_duty_defines.svh"

module adaptive_velocity_to_duty #(
  parameter int unsigned WINDOW_DEPTH = 200
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  avtd_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output avtd_pkg::out_beat_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [avtd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [avtd_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import avtd_pkg::*;

  localparam int unsigned AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SDS_W  = PDS_W + FILL_W;
  localparam int unsigned SDD_W  = PDD_W + FILL_W;
  localparam int unsigned DW     = SDS_W + 8;
  localparam int unsigned DVS_W  = SDD_W;
  localparam int unsigned CNT_W  = $clog2(DW + 1);
  localparam int unsigned ENT_W  = DUTY_W + MAG_W;

  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(WINDOW_DEPTH);
  localparam logic [AW:0]       DEPTH_S = (AW + 1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0]     LAST_A  = AW'(WINDOW_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SUB, S_ADD, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t              state_r;
  logic                out_valid_r;
  out_beat_t           out_data_r;

  // configuration
  logic [DUTY_W-1:0]   duty_limit_r;
  logic [CAPT_W-1:0]   capture_speed_r;
  logic [GAIN_W-1:0]   gain_floor_r;
  logic [GAIN_W-1:0]   gain_ceiling_r;

  // block state
  logic [FILL_W-1:0]   fill_r;
  logic [AW-1:0]       head_r;
  logic [SDS_W-1:0]    sum_ds_r;
  logic [SDD_W-1:0]    sum_dd_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [DUTY_W-1:0]   last_duty_r;
  logic                last_dir_r;
  logic                first_cmd_r;

  // per-item working registers
  logic                dir_write_r;
  logic                upd_r;
  logic                was_full_r;
  logic                op_fit_r;
  logic [MAG_W-1:0]    mag_r;
  logic [PDS_W-1:0]    new_ds_r;
  logic [PDD_W-1:0]    new_dd_r;
  logic [PDS_W-1:0]    old_ds_r;
  logic [PDD_W-1:0]    old_dd_r;

  // serial divider
  logic [DW-1:0]       dvd_r;
  logic [DVS_W-1:0]    dvs_r;
  logic [DVS_W-1:0]    rem_r;
  logic [GAIN_W-1:0]   quo_r;
  logic                ovf_r;
  logic [CNT_W-1:0]    cnt_r;

  // sample memory
  logic [ENT_W-1:0]    win_mem [WINDOW_DEPTH];
  logic [ENT_W-1:0]    mem_rdata_r;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [ENT_W-1:0]    mem_wdata;

  // combinational helpers
  logic                in_accept;
  logic                neg;
  logic [SPEED_W-1:0]  sv_bits;
  logic [MAG_W-1:0]    mag;
  logic                capture;
  logic                win_full;
  logic [AW:0]         slot_sum;
  logic [AW-1:0]       slot;
  logic [SDS_W-1:0]    sum_ds_nxt;
  logic [SDD_W-1:0]    sum_dd_nxt;
  logic [DVS_W:0]      rem_sh;
  logic [DVS_W:0]      rem_trial;
  logic                rem_fits;
  logic [DUTY_W-1:0]   od;
  logic [MAG_W-1:0]    om;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // speed magnitude and sign, capture test
  assign sv_bits  = in_data.speed_value;
  assign neg      = sv_bits[SPEED_W-1];
  assign mag      = neg ? (~sv_bits + 16'd1) : sv_bits;
  assign capture  = (mag > {1'b0, capture_speed_r});
  assign win_full = (fill_r >= DEPTH_F);

  // next free slot while the window is filling
  assign slot_sum = {1'b0, head_r} + {1'b0, fill_r[AW-1:0]};
  assign slot     = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : slot_sum[AW-1:0];

  // running sums with the new pair added
  assign sum_ds_nxt = sum_ds_r + SDS_W'(new_ds_r);
  assign sum_dd_nxt = sum_dd_r + SDD_W'(new_dd_r);

  // one restoring divide step
  assign rem_sh    = {rem_r, dvd_r[DW-1]};
  assign rem_trial = rem_sh - {1'b0, dvs_r};
  assign rem_fits  = (rem_sh >= {1'b0, dvs_r});

  // oldest entry fields
  assign od = mem_rdata_r[ENT_W-1:MAG_W];
  assign om = mem_rdata_r[MAG_W-1:0];

  // memory port control: fill writes at accept, replacement after the read
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = {last_duty_r, mag};
    if (state_r == S_RD) begin
      mem_we    = 1'b1;
      mem_waddr = head_r;
      mem_wdata = {last_duty_r, mag_r};
    end else if (in_accept && (in_data.mode == MODE_ODOMETRY) && capture) begin
      mem_re = win_full;
      mem_we = !win_full;
    end
  end

  // sample memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata_r <= win_mem[head_r];
    end
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      duty_limit_r    <= DUTY_LIMIT_RST;
      capture_speed_r <= CAPTURE_SPEED_RST;
      gain_floor_r    <= GAIN_FLOOR_RST;
      gain_ceiling_r  <= GAIN_CEILING_RST;
      fill_r          <= '0;
      head_r          <= '0;
      sum_ds_r        <= '0;
      sum_dd_r        <= '0;
      gain_r          <= GAIN_START_RST;
      last_duty_r     <= '0;
      last_dir_r      <= 1'b0;
      first_cmd_r     <= 1'b1;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DUTY_LIMIT:    duty_limit_r    <= cfg_data[DUTY_W-1:0];
          REG_CAPTURE_SPEED: capture_speed_r <= cfg_data[CAPT_W-1:0];
          REG_GAIN_FLOOR:    gain_floor_r    <= cfg_data[GAIN_W-1:0];
          REG_GAIN_CEILING:  gain_ceiling_r  <= cfg_data[GAIN_W-1:0];
          REG_GAIN_START:    gain_r          <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      // result taken by the receiver, unless a new one is loaded now
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            upd_r <= 1'b0;
            if (in_data.mode == MODE_COMMAND) begin
              dir_write_r <= first_cmd_r || (neg != last_dir_r);
              first_cmd_r <= 1'b0;
              last_dir_r  <= neg;
              op_fit_r    <= 1'b0;
              if (gain_r == '0) begin
                last_duty_r <= duty_limit_r;
                state_r     <= S_OUT;
              end else begin
                dvd_r   <= DW'({mag, 8'd0});
                dvs_r   <= DVS_W'(gain_r);
                rem_r   <= '0;
                quo_r   <= '0;
                ovf_r   <= 1'b0;
                cnt_r   <= CNT_W'(DW);
                state_r <= S_DIV;
              end
            end else begin
              dir_write_r <= 1'b0;
              if (capture) begin
                was_full_r <= win_full;
                mag_r      <= mag;
                new_ds_r   <= last_duty_r * mag;
                new_dd_r   <= last_duty_r * last_duty_r;
                if (win_full) begin
                  state_r <= S_RD;
                end else begin
                  fill_r  <= fill_r + 1'b1;
                  state_r <= S_ADD;
                end
              end else begin
                state_r <= S_OUT;
              end
            end
          end
        end

        // oldest pair arrives, replace it and advance the head
        S_RD: begin
          old_ds_r <= od * om;
          old_dd_r <= od * od;
          head_r   <= (head_r == LAST_A) ? '0 : head_r + 1'b1;
          state_r  <= S_SUB;
        end

        // drop the oldest pair from the sums
        S_SUB: begin
          sum_ds_r <= sum_ds_r - SDS_W'(old_ds_r);
          sum_dd_r <= sum_dd_r - SDD_W'(old_dd_r);
          state_r  <= S_ADD;
        end

        // add the new pair, start the fit once the window was full and the duty-squared sum is not zero
        S_ADD: begin
          sum_ds_r <= sum_ds_nxt;
          sum_dd_r <= sum_dd_nxt;
          if (was_full_r && (sum_dd_nxt != '0)) begin
            op_fit_r <= 1'b1;
            dvd_r    <= {sum_ds_nxt, 8'd0};
            dvs_r    <= sum_dd_nxt;
            rem_r    <= '0;
            quo_r    <= '0;
            ovf_r    <= 1'b0;
            cnt_r    <= CNT_W'(DW);
            state_r  <= S_DIV;
          end else begin
            state_r <= S_OUT;
          end
        end

        // one quotient bit per cycle, high bits fold into overflow
        S_DIV: begin
          dvd_r <= {dvd_r[DW-2:0], 1'b0};
          rem_r <= rem_fits ? rem_trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
          quo_r <= {quo_r[GAIN_W-2:0], rem_fits};
          ovf_r <= ovf_r | quo_r[GAIN_W-1];
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= S_FIN;
          end
        end

        // saturate the duty or qualify the fitted gain
        S_FIN: begin
          if (op_fit_r) begin
            if (!ovf_r && (quo_r > gain_floor_r) && (quo_r < gain_ceiling_r)) begin
              gain_r <= quo_r;
              upd_r  <= 1'b1;
            end
          end else if (ovf_r || (quo_r > GAIN_W'(duty_limit_r))) begin
            last_duty_r <= duty_limit_r;
          end else begin
            last_duty_r <= quo_r[DUTY_W-1:0];
          end
          state_r <= S_OUT;
        end

        // hand the result to the output register once it is free
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r                <= 1'b1;
            out_data_r.duty            <= last_duty_r;
            out_data_r.direction       <= last_dir_r;
            out_data_r.direction_write <= dir_write_r;
            out_data_r.gain            <= gain_r;
            out_data_r.gain_updated    <= upd_r;
            state_r                    <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // window bookkeeping, handshake and divider checks
  `AVTD_ASSERT_ALWAYS(a_fill_bound, fill_r <= DEPTH_F, "window fill beyond depth")
  `AVTD_ASSERT_IMP(a_head_still, fill_r < DEPTH_F, head_r == '0, "head moved before window full")
  `AVTD_ASSERT_NXT(a_accept_busy, in_accept, in_stall, "second beat taken while busy")
  `AVTD_ASSERT_IMP(a_fit_divisor, (state_r == S_DIV) && op_fit_r, dvs_r != '0, "fit with zero sum")

endmodule
